// File: src/cluster_size_histogrammer_macros.svh
// Assertion macros for the cluster size histogrammer.
`ifndef CLUSTER_SIZE_HISTOGRAMMER_MACROS_SVH
`define CLUSTER_SIZE_HISTOGRAMMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSH_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csh assertion failed");

// Next-cycle implication, disabled during reset.
`define CSH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csh assertion failed");

`endif

// File: src/csh_pkg.sv
// Shared constants and types for the cluster size histogrammer.
`timescale 1ns / 1ps
`default_nettype none

package csh_pkg;

  localparam int CYLINDERS = 256;
  localparam int PARENTS   = 16;
  localparam int SIZE_BINS = 64;

  localparam int SLOTS      = CYLINDERS * PARENTS;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BIN_W      = $clog2(SIZE_BINS);
  localparam int CNT_W      = BIN_W;
  localparam int WORD_W     = 3 * CNT_W;
  localparam int HA_W       = BIN_W + 2;
  localparam int HIST_DEPTH = 3 << BIN_W;
  localparam int CLR_LEN    = (SLOTS > HIST_DEPTH) ? SLOTS : HIST_DEPTH;
  localparam int CLR_W      = $clog2(CLR_LEN);

  localparam int COPY_W   = 8;
  localparam int PARENT_W = 4;
  localparam int SIZE_W   = 6;
  localparam int FREQ_W   = 32;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [1:0] {
    ACT_HIT   = 2'd0,
    ACT_EOE   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } act_t;

  // counter category, also the histogram bank
  typedef enum logic [1:0] {
    CAT_ION = 2'd0,
    CAT_EXC = 2'd1,
    CAT_TOT = 2'd2
  } cat_t;

endpackage

`default_nettype wire

// File: src/cluster_size_histogrammer.sv
// Cluster size histogrammer: per-slot counters, histogram binning and readout.
// Hit: dropped if ignored, else counter read, load, three passes of the
//   shared incrementer, write back. End of event: per slot a counter read, then a
//   load that clears it, a histogram update per nonzero counter; all SLOTS slots.
// Readout: per row three reads and a beat awaiting out_tready; empty: one zero row.
// Reset and clear: CLR_LEN sweep zeroing both memories, not ready.
`timescale 1ns / 1ps
`default_nettype none
`include "cluster_size_histogrammer_macros.svh"

module cluster_size_histogrammer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wen,
  input  wire logic                               cfg_wdata,   // repeated_geometry
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // is_ionisation, is_excitation, cylinder_copy[7:0], parent_copy[3:0], pad
  input  wire logic [csh_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic [csh_pkg::IN_USER_W-1:0]      in_tuser,    // action
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // cluster_size[5:0], ionisation_freq, excitation_freq, total_freq, pad
  output logic [csh_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic                                    out_tlast    // last_row
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HLOAD, S_HBUMP, S_HWR,
    S_ERD, S_ELOAD, S_EHRD, S_EHINC, S_RCAP, S_ROUT
  } state_t;

  state_t                         state_r, state_nxt;
  logic                           rep_r, rep_nxt;
  logic [csh_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic [csh_pkg::WORD_W-1:0]     word_r, word_nxt;
  logic [1:0]                     k_r, k_nxt;
  logic                           hit_ion_r, hit_ion_nxt;
  logic                           hit_exc_r, hit_exc_nxt;
  logic [csh_pkg::CLR_W-1:0]      clr_r, clr_nxt;
  logic [csh_pkg::BIN_W-1:0]      top_r, top_nxt;
  logic                           top_vld_r, top_vld_nxt;
  logic [csh_pkg::BIN_W-1:0]      row_r, row_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_last_r, out_last_nxt;
  logic [csh_pkg::FREQ_W-1:0]     out_ion_r, out_ion_nxt;
  logic [csh_pkg::FREQ_W-1:0]     out_exc_r, out_exc_nxt;
  logic [csh_pkg::FREQ_W-1:0]     out_tot_r, out_tot_nxt;

  // counter memory: {total, exc, ion} per slot
  logic [csh_pkg::WORD_W-1:0]     cnt_mem [csh_pkg::SLOTS];
  logic                           cnt_we, cnt_re;
  logic [csh_pkg::SLOT_W-1:0]     cnt_waddr, cnt_raddr;
  logic [csh_pkg::WORD_W-1:0]     cnt_wdata;
  logic [csh_pkg::WORD_W-1:0]     cnt_rdata_r;

  // histogram memory: address {category, bin}
  logic [csh_pkg::FREQ_W-1:0]     hist_mem [csh_pkg::HIST_DEPTH];
  logic                           hist_we, hist_re;
  logic [csh_pkg::HA_W-1:0]       hist_waddr, hist_raddr;
  logic [csh_pkg::FREQ_W-1:0]     hist_wdata;
  logic [csh_pkg::FREQ_W-1:0]     hist_rdata_r;

  // shared saturating incrementer
  logic [csh_pkg::FREQ_W-1:0]     unit_a, unit_lim, unit_y;

  logic                           in_fire;
  csh_pkg::act_t                  in_action;
  logic                           in_ion, in_exc;
  logic [csh_pkg::COPY_W-1:0]     in_copy;
  logic [csh_pkg::PARENT_W-1:0]   in_parent, parent_eff;
  logic                           hit_ok;
  logic [csh_pkg::SLOT_W-1:0]     hit_slot;
  logic [csh_pkg::CNT_W-1:0]      cur_field;
  logic                           field_en;

  assign in_action = csh_pkg::act_t'(in_tuser[1:0]);
  assign in_ion    = in_tdata[0];
  assign in_exc    = in_tdata[1];
  assign in_copy   = in_tdata[9:2];
  assign in_parent = in_tdata[13:10];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign parent_eff = rep_r ? in_parent : '0;
  assign hit_ok = (in_ion || in_exc) && !(rep_r && (in_copy == '0)) &&
                  (32'(in_copy) < 32'(csh_pkg::CYLINDERS)) &&
                  (32'(parent_eff) < 32'(csh_pkg::PARENTS));
  assign hit_slot = csh_pkg::SLOT_W'(32'(parent_eff) * csh_pkg::CYLINDERS + 32'(in_copy));

  assign cur_field = word_r[k_r*csh_pkg::CNT_W +: csh_pkg::CNT_W];

  always_comb begin
    unique case (k_r)
      csh_pkg::CAT_ION: field_en = hit_ion_r;
      csh_pkg::CAT_EXC: field_en = hit_exc_r;
      default:          field_en = 1'b1;
    endcase
  end

  assign unit_y = (unit_a < unit_lim) ? unit_a + 32'd1 : unit_a;

  always_comb begin
    state_nxt     = state_r;
    rep_nxt       = cfg_wen ? cfg_wdata : rep_r;
    slot_nxt      = slot_r;
    word_nxt      = word_r;
    k_nxt         = k_r;
    hit_ion_nxt   = hit_ion_r;
    hit_exc_nxt   = hit_exc_r;
    clr_nxt       = clr_r;
    top_nxt       = top_r;
    top_vld_nxt   = top_vld_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_ion_nxt   = out_ion_r;
    out_exc_nxt   = out_exc_r;
    out_tot_nxt   = out_tot_r;
    cnt_we        = 1'b0;
    cnt_waddr     = slot_r;
    cnt_wdata     = '0;
    cnt_re        = 1'b0;
    cnt_raddr     = slot_r;
    hist_we       = 1'b0;
    hist_waddr    = {k_r, cur_field};
    hist_wdata    = unit_y;
    hist_re       = 1'b0;
    hist_raddr    = {k_r, cur_field};
    unit_a        = '0;
    unit_lim      = '0;

    unique case (state_r)
      S_CLR: begin
        cnt_we     = (32'(clr_r) < 32'(csh_pkg::SLOTS));
        cnt_waddr  = clr_r[csh_pkg::SLOT_W-1:0];
        cnt_wdata  = '0;
        hist_we    = (32'(clr_r) < 32'(csh_pkg::HIST_DEPTH));
        hist_waddr = clr_r[csh_pkg::HA_W-1:0];
        hist_wdata = '0;
        if (clr_r == csh_pkg::CLR_W'(csh_pkg::CLR_LEN - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_action)
            csh_pkg::ACT_HIT: begin
              if (hit_ok) begin
                cnt_re      = 1'b1;
                cnt_raddr   = hit_slot;
                slot_nxt    = hit_slot;
                hit_ion_nxt = in_ion;
                hit_exc_nxt = in_exc;
                state_nxt   = S_HLOAD;
              end
            end
            csh_pkg::ACT_EOE: begin
              slot_nxt  = '0;
              state_nxt = S_ERD;
            end
            csh_pkg::ACT_READ: begin
              row_nxt = '0;
              k_nxt   = csh_pkg::CAT_ION;
              if (top_vld_r) begin
                hist_re    = 1'b1;
                hist_raddr = {csh_pkg::CAT_ION, {csh_pkg::BIN_W{1'b0}}};
                state_nxt  = S_RCAP;
              end else begin
                // empty histogram: single zero row
                out_ion_nxt   = '0;
                out_exc_nxt   = '0;
                out_tot_nxt   = '0;
                out_last_nxt  = 1'b1;
                out_valid_nxt = 1'b1;
                state_nxt     = S_ROUT;
              end
            end
            default: begin
              clr_nxt     = '0;
              top_vld_nxt = 1'b0;
              state_nxt   = S_CLR;
            end
          endcase
        end
      end
      S_HLOAD: begin
        word_nxt  = cnt_rdata_r;
        k_nxt     = csh_pkg::CAT_ION;
        state_nxt = S_HBUMP;
      end
      S_HBUMP: begin
        unit_a   = csh_pkg::FREQ_W'(cur_field);
        unit_lim = csh_pkg::FREQ_W'(csh_pkg::SIZE_BINS - 1);
        if (field_en) begin
          word_nxt[k_r*csh_pkg::CNT_W +: csh_pkg::CNT_W] = unit_y[csh_pkg::CNT_W-1:0];
        end
        if (k_r == csh_pkg::CAT_TOT) begin
          state_nxt = S_HWR;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_HWR: begin
        cnt_we    = 1'b1;
        cnt_wdata = word_r;
        state_nxt = S_IDLE;
      end
      S_ERD: begin
        cnt_re    = 1'b1;
        state_nxt = S_ELOAD;
      end
      S_ELOAD: begin
        word_nxt  = cnt_rdata_r;
        cnt_we    = 1'b1;
        cnt_wdata = '0;
        k_nxt     = csh_pkg::CAT_ION;
        state_nxt = S_EHRD;
      end
      S_EHRD, S_EHINC: begin
        if (state_r == S_EHRD && cur_field != '0) begin
          hist_re   = 1'b1;
          state_nxt = S_EHINC;
        end else begin
          if (state_r == S_EHINC) begin
            unit_a   = hist_rdata_r;
            unit_lim = '1;
            hist_we  = 1'b1;
            if (k_r == csh_pkg::CAT_TOT && (!top_vld_r || cur_field > top_r)) begin
              top_nxt     = cur_field;
              top_vld_nxt = 1'b1;
            end
          end
          // move on to the next category, or the next slot
          if (k_r == csh_pkg::CAT_TOT) begin
            if (slot_r == csh_pkg::SLOT_W'(csh_pkg::SLOTS - 1)) begin
              state_nxt = S_IDLE;
            end else begin
              slot_nxt  = slot_r + 1'b1;
              state_nxt = S_ERD;
            end
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_EHRD;
          end
        end
      end
      S_RCAP: begin
        unique case (k_r)
          csh_pkg::CAT_ION: out_ion_nxt = hist_rdata_r;
          csh_pkg::CAT_EXC: out_exc_nxt = hist_rdata_r;
          default:          out_tot_nxt = hist_rdata_r;
        endcase
        if (k_r == csh_pkg::CAT_TOT) begin
          out_last_nxt  = (row_r == top_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_ROUT;
        end else begin
          hist_re    = 1'b1;
          hist_raddr = {k_r + 2'd1, row_r};
          k_nxt      = k_r + 2'd1;
        end
      end
      S_ROUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            row_nxt    = row_r + 1'b1;
            k_nxt      = csh_pkg::CAT_ION;
            hist_re    = 1'b1;
            hist_raddr = {csh_pkg::CAT_ION, row_r + 1'b1};
            state_nxt  = S_RCAP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      rep_r       <= 1'b0;
      clr_r       <= '0;
      top_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rep_r       <= rep_nxt;
      clr_r       <= clr_nxt;
      top_vld_r   <= top_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r     <= slot_nxt;
    word_r     <= word_nxt;
    k_r        <= k_nxt;
    hit_ion_r  <= hit_ion_nxt;
    hit_exc_r  <= hit_exc_nxt;
    top_r      <= top_nxt;
    row_r      <= row_nxt;
    out_last_r <= out_last_nxt;
    out_ion_r  <= out_ion_nxt;
    out_exc_r  <= out_exc_nxt;
    out_tot_r  <= out_tot_nxt;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_r <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rdata_r <= hist_mem[hist_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_tot_r, out_exc_r, out_ion_r, csh_pkg::SIZE_W'(row_r)};

  // never take input while a row is pending
  `CSH_ASSERT_IMPL(a_ready_vs_out, in_tready, !out_tvalid)
  // the final readout beat returns the block to idle
  `CSH_ASSERT_NEXT(a_last_to_idle, out_tvalid && out_tready && out_tlast, in_tready)
  // a final row with zero total only comes from the empty readout at size 0
  `CSH_ASSERT_IMPL(a_top_nonzero, out_tvalid && out_tlast && (out_tdata[101:70] == 32'd0),
                   out_tdata[5:0] == 6'd0)

endmodule

`default_nettype wire
